### rtl/assert_macros.svh
// assertion macros shared by the arp cache responder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ARPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ARPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ARPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/arpc_pkg.sv
// shared types and constants of the arp cache responder
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_MAC    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GATEWAY_IP = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NET_MASK   = 2'd3;

  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
  localparam logic [7:0]  PLEN_IPV4      = 8'd4;
  localparam logic [15:0] OPC_REQUEST    = 16'h0001;
  localparam logic [15:0] OPC_REPLY      = 16'h0002;

  localparam logic [1:0] FOP_NONE    = 2'd0;
  localparam logic [1:0] FOP_REQUEST = 2'd1;
  localparam logic [1:0] FOP_REPLY   = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_REPLIED  = 3'd2;
  localparam logic [2:0] ST_LEARNED  = 3'd3;
  localparam logic [2:0] ST_NOT_OURS = 3'd4;
  localparam logic [2:0] ST_BAD      = 3'd5;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] query_ip;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arpc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] resolved_mac;
    logic        send_frame;
    logic [47:0] frame_dest_mac;
    logic [1:0]  frame_opcode;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
  } arpc_out_t;

  typedef struct packed {
    logic load;
    logic scan_run;
    logic learn;
    logic emit;
  } arpc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } arpc_sts_t;

endpackage

### rtl/arpc_ctrl.sv
// sequencing fsm: accept, cache scan, result and cache update
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  arpc_pkg::arpc_sts_t sts,
  output arpc_pkg::arpc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        // wait for the output register, then update the cache with the same edge
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.learn = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ARPC_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "emit while output busy")
  `ARPC_ASSERT_NXT(a_load_scan, clk, rst_n, cmd.load, state_r == S_SCAN, "no scan after load")
  `ARPC_ASSERT_IMP(a_learn_emit, clk, rst_n, cmd.learn, cmd.emit, "learn without result")

endmodule

### rtl/arpc_dp.sv
// datapath: config registers, cache memory, scan and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arpc_dp #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [arpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  arpc_pkg::arpc_in_t              in_data,
  input  arpc_pkg::arpc_cmd_t             cmd,
  output arpc_pkg::arpc_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output arpc_pkg::arpc_out_t             out_data
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CACHE_ENTRIES);

  // configuration
  logic [31:0] own_ip_r;
  logic [47:0] own_mac_r;
  logic [31:0] gateway_ip_r;
  logic [31:0] net_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r     <= '0;
      own_mac_r    <= '0;
      gateway_ip_r <= '0;
      net_mask_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        arpc_pkg::CFG_OWN_IP:     own_ip_r     <= cfg_wdata[31:0];
        arpc_pkg::CFG_OWN_MAC:    own_mac_r    <= cfg_wdata[47:0];
        arpc_pkg::CFG_GATEWAY_IP: gateway_ip_r <= cfg_wdata[31:0];
        arpc_pkg::CFG_NET_MASK:   net_mask_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // item capture
  arpc_pkg::arpc_in_t item_r;
  logic [31:0]        ip_r;
  logic               bad_r;
  logic               off_net;
  logic               bad_hdr;

  assign off_net = (in_data.query_ip & net_mask_r) != (gateway_ip_r & net_mask_r);
  assign bad_hdr = (in_data.hw_type != arpc_pkg::HTYPE_ETHERNET)
                || (in_data.proto_type != arpc_pkg::PTYPE_IPV4)
                || (in_data.hw_addr_len != arpc_pkg::HLEN_ETHERNET)
                || (in_data.proto_addr_len != arpc_pkg::PLEN_IPV4)
                || ((in_data.arp_opcode != arpc_pkg::OPC_REQUEST)
                    && (in_data.arp_opcode != arpc_pkg::OPC_REPLY));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      ip_r   <= off_net ? gateway_ip_r : in_data.query_ip;
      bad_r  <= bad_hdr;
    end
  end

  // cache storage
  logic [47:0]              mem_mac [CACHE_ENTRIES];
  logic [31:0]              mem_ip  [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [CACHE_ENTRIES-1:0] valid_nxt;

  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_live;
  logic             rd_act_r;
  logic             rd_vld_r;
  logic [47:0]      rd_mac_r;
  logic [31:0]      rd_ip_r;
  logic             hit_found_r;
  logic [47:0]      hit_mac_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             learn_en;
  logic [IDX_W-1:0] wr_idx;

  assign scan_idx  = cnt_r[IDX_W-1:0];
  assign scan_live = cmd.scan_run && (cnt_r < CNT_END);
  assign learn_en  = cmd.learn && (item_r.operation == arpc_pkg::OP_PACKET) && !bad_r;
  assign wr_idx    = free_found_r ? free_idx_r : '0;

  always_comb begin
    valid_nxt = valid_r;
    if (learn_en) begin
      valid_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (learn_en) begin
      mem_mac[wr_idx] <= item_r.sender_mac;
      mem_ip[wr_idx]  <= item_r.sender_ip;
    end
    if (scan_live) begin
      rd_mac_r <= mem_mac[scan_idx];
      rd_ip_r  <= mem_ip[scan_idx];
      rd_vld_r <= valid_r[scan_idx];
    end
  end

  // one entry read per cycle, compared in the next cycle from the read registers; first match and first hole win
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      rd_act_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r        <= '0;
      rd_act_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_act_r <= scan_live;
      if (scan_live) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (!valid_r[scan_idx] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= scan_idx;
        end
      end
      if (rd_act_r && rd_vld_r && (rd_ip_r == ip_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_mac_r   <= rd_mac_r;
      end
    end
  end

  assign sts.scan_done = (cnt_r == CNT_END) && !rd_act_r;

  // result
  arpc_pkg::arpc_out_t res;

  always_comb begin
    res = '0;
    if (item_r.operation == arpc_pkg::OP_LOOKUP) begin
      if (hit_found_r) begin
        res.status       = arpc_pkg::ST_HIT;
        res.resolved_mac = hit_mac_r;
      end else begin
        res.status          = arpc_pkg::ST_MISS;
        res.send_frame      = 1'b1;
        res.frame_dest_mac  = arpc_pkg::BCAST_MAC;
        res.frame_opcode    = arpc_pkg::FOP_REQUEST;
        res.frame_target_ip = ip_r;
      end
    end else if (bad_r) begin
      res.status = arpc_pkg::ST_BAD;
    end else if (item_r.arp_opcode == arpc_pkg::OPC_REPLY) begin
      res.status = arpc_pkg::ST_LEARNED;
    end else if (item_r.target_ip != own_ip_r) begin
      res.status = arpc_pkg::ST_NOT_OURS;
    end else begin
      res.status           = arpc_pkg::ST_REPLIED;
      res.send_frame       = 1'b1;
      res.frame_dest_mac   = item_r.sender_mac;
      res.frame_opcode     = arpc_pkg::FOP_REPLY;
      res.frame_target_mac = item_r.sender_mac;
      res.frame_target_ip  = item_r.sender_ip;
    end
  end

  // output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  arpc_pkg::arpc_out_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  `ARPC_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_END, "scan counter past cache depth")
  `ARPC_ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_r, "result not presented")
  `ARPC_ASSERT_IMP(a_done_quiet, clk, rst_n, sts.scan_done && cmd.scan_run, !scan_live,
                   "memory read after scan end")

endmodule

### rtl/arp_cache_responder_unit.sv
// top level of the arp cache responder
`timescale 1ns / 1ps
// ARP cache with a small responder.
// in_valid/in_ready/in_data carry one item: a lookup (resolve an IPv4 address,
// off-subnet addresses go to the gateway) or a decoded received ARP packet.
// out_valid/out_ready/out_data carry exactly one result item per input item.
// cfg_we/cfg_addr/cfg_wdata write own_ip, own_mac, gateway_ip and net_mask;
// write them only while the block is idle.
// For each item the sequencer walks the cache one entry per cycle through
// the single read port of the entry memory, then, once the output register
// is free, presents the result and stores a learned sender in the same
// cycle. One item is in flight at a time, so a new item is accepted only
// after the previous result has been written to the output register.
// A finished result waits in the output register; while it is stalled the
// next item may be accepted and scanned, and its result waits until the
// output register is taken.
// Reset empties the cache (valid bits cleared at once), zeroes the
// configuration and drops any pending result.
module arp_cache_responder_unit #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [arpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  arpc_pkg::arpc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output arpc_pkg::arpc_out_t             out_data
);

  arpc_pkg::arpc_cmd_t cmd;
  arpc_pkg::arpc_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arpc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sim/tb_top.sv
// self-checking testbench for the arp cache responder: directed and random items against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRIES     = arpc_pkg::CACHE_ENTRIES_DEF;
  localparam int LATENCY     = ENTRIES + 3;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 24;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [arpc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  arpc_pkg::arpc_in_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  arpc_pkg::arpc_out_t             out_data;

  arp_cache_responder_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and cache contents as the block should hold them
  logic [31:0] my_ip       = '0;
  logic [31:0] gw_ip       = '0;
  logic [31:0] subnet_mask = '0;
  logic        slot_used [ENTRIES];
  logic [47:0] slot_mac  [ENTRIES];
  logic [31:0] slot_ip   [ENTRIES];

  arpc_pkg::arpc_in_t  send_q[$];
  arpc_pkg::arpc_out_t expected_q[$];

  int err_count  = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;
  bit in_busy    = 1'b0;
  bit in_took    = 1'b0;

  function automatic arpc_pkg::arpc_out_t arp_outcome(arpc_pkg::arpc_in_t it);
    arpc_pkg::arpc_out_t r;
    logic [31:0]         ip;
    int                  slot;
    r = '0;
    if (it.operation == arpc_pkg::OP_LOOKUP) begin
      ip = it.query_ip;
      if ((ip & subnet_mask) != (gw_ip & subnet_mask)) ip = gw_ip;
      // descending walk leaves the lowest matching entry
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (slot_used[i] && slot_ip[i] == ip) slot = i;
      if (slot >= 0) begin
        r.status       = arpc_pkg::ST_HIT;
        r.resolved_mac = slot_mac[slot];
      end else begin
        r.status          = arpc_pkg::ST_MISS;
        r.send_frame      = 1'b1;
        r.frame_dest_mac  = arpc_pkg::BCAST_MAC;
        r.frame_opcode    = arpc_pkg::FOP_REQUEST;
        r.frame_target_ip = ip;
      end
      return r;
    end
    if (it.hw_type != arpc_pkg::HTYPE_ETHERNET || it.proto_type != arpc_pkg::PTYPE_IPV4 ||
        it.hw_addr_len != arpc_pkg::HLEN_ETHERNET ||
        it.proto_addr_len != arpc_pkg::PLEN_IPV4 ||
        (it.arp_opcode != arpc_pkg::OPC_REQUEST && it.arp_opcode != arpc_pkg::OPC_REPLY))
    begin
      r.status = arpc_pkg::ST_BAD;
      return r;
    end
    // first unused entry, entry 0 once the cache is full
    slot = 0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!slot_used[i]) slot = i;
    slot_used[slot] = 1'b1;
    slot_mac[slot]  = it.sender_mac;
    slot_ip[slot]   = it.sender_ip;
    if (it.arp_opcode == arpc_pkg::OPC_REPLY) begin
      r.status = arpc_pkg::ST_LEARNED;
    end else if (it.target_ip != my_ip) begin
      r.status = arpc_pkg::ST_NOT_OURS;
    end else begin
      r.status           = arpc_pkg::ST_REPLIED;
      r.send_frame       = 1'b1;
      r.frame_dest_mac   = it.sender_mac;
      r.frame_opcode     = arpc_pkg::FOP_REPLY;
      r.frame_target_mac = it.sender_mac;
      r.frame_target_ip  = it.sender_ip;
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR %0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", field, got, want));
  endtask

  // input acceptance feeds the predictor, result acceptance is checked
  always @(posedge clk) begin : monitor
    arpc_pkg::arpc_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(arp_outcome(in_data));
        in_took = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_error("result item with nothing expected");
        end else begin
          want = expected_q.pop_front();
          compare_field("status", 64'(out_data.status), 64'(want.status));
          compare_field("resolved_mac", 64'(out_data.resolved_mac),
                        64'(want.resolved_mac));
          compare_field("send_frame", 64'(out_data.send_frame), 64'(want.send_frame));
          compare_field("frame_dest_mac", 64'(out_data.frame_dest_mac),
                        64'(want.frame_dest_mac));
          compare_field("frame_opcode", 64'(out_data.frame_opcode),
                        64'(want.frame_opcode));
          compare_field("frame_target_mac", 64'(out_data.frame_target_mac),
                        64'(want.frame_target_mac));
          compare_field("frame_target_ip", 64'(out_data.frame_target_ip),
                        64'(want.frame_target_ip));
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    if (rst_n) begin
      if (in_took) begin
        in_took = 1'b0;
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_q.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 15);
          end else begin
            in_data <= send_q.pop_front();
            in_busy = 1'b1;
          end
        end
      end
      in_valid <= in_busy;
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      // long hold-off so the block backs up and stalls its input
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [arpc_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [arpc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      arpc_pkg::CFG_OWN_IP:     my_ip = value[31:0];
      arpc_pkg::CFG_GATEWAY_IP: gw_ip = value[31:0];
      arpc_pkg::CFG_NET_MASK:   subnet_mask = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits of the 32-bit registers carry junk that must be dropped
  task automatic program_regs(input logic [31:0] ip, input logic [47:0] mac,
                              input logic [31:0] gw, input logic [31:0] mask);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(arpc_pkg::CFG_OWN_IP, {junk[15:0], ip});
    write_reg(arpc_pkg::CFG_OWN_MAC, mac);
    write_reg(arpc_pkg::CFG_GATEWAY_IP, {junk[31:16], gw});
    write_reg(arpc_pkg::CFG_NET_MASK, {junk[47:32], mask});
  endtask

  function automatic arpc_pkg::arpc_in_t arp_packet(logic [15:0] opc, logic [47:0] smac,
                                                    logic [31:0] sip, logic [31:0] tip);
    arpc_pkg::arpc_in_t it;
    it                = '0;
    it.operation      = arpc_pkg::OP_PACKET;
    it.hw_type        = arpc_pkg::HTYPE_ETHERNET;
    it.proto_type     = arpc_pkg::PTYPE_IPV4;
    it.hw_addr_len    = arpc_pkg::HLEN_ETHERNET;
    it.proto_addr_len = arpc_pkg::PLEN_IPV4;
    it.arp_opcode     = opc;
    it.sender_mac     = smac;
    it.sender_ip      = sip;
    it.target_ip      = tip;
    return it;
  endfunction

  function automatic arpc_pkg::arpc_in_t lookup_item(logic [31:0] ip);
    arpc_pkg::arpc_in_t it;
    it           = '0;
    it.operation = arpc_pkg::OP_LOOKUP;
    it.query_ip  = ip;
    return it;
  endfunction

  task automatic queue_random(input int count);
    arpc_pkg::arpc_in_t it;
    logic [255:0]       noise;
    logic [31:0]        pool [POOL_SIZE];
    logic [31:0]        subnet;
    logic [15:0]        flip16;
    logic [7:0]         flip8;
    int                 r;
    // small host numbers inside the subnet so senders repeat and lookups hit
    subnet = gw_ip & subnet_mask;
    foreach (pool[k]) pool[k] = subnet | ($urandom_range(1, 40) & ~subnet_mask);
    pool[0] = gw_ip;
    pool[1] = my_ip;
    repeat (count) begin
      noise = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(arpc_pkg::arpc_in_t)-1:0];
      r  = $urandom_range(0, 99);
      if (r < 45) begin
        it.operation = arpc_pkg::OP_LOOKUP;
        case ($urandom_range(0, 3))
          0, 1: it.query_ip = pool[$urandom_range(0, POOL_SIZE - 1)];
          2:    it.query_ip = subnet | (noise[255:224] & ~subnet_mask);
          default: ;
        endcase
      end else begin
        it = arp_packet($urandom_range(0, 1) ? arpc_pkg::OPC_REQUEST : arpc_pkg::OPC_REPLY,
                        noise[79:32],
                        ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                                    : noise[111:80],
                        $urandom_range(0, 1) ? my_ip : noise[143:112]);
        it.query_ip = noise[175:144];
        if (r >= 85) begin
          flip16 = noise[239:224];
          if (flip16 == '0) flip16 = 16'h0001;
          flip8 = noise[247:240];
          if (flip8 == '0) flip8 = 8'h01;
          case ($urandom_range(0, 4))
            0: it.hw_type        ^= flip16;
            1: it.proto_type     ^= flip16;
            2: it.hw_addr_len    ^= flip8;
            3: it.proto_addr_len ^= flip8;
            default: begin
              it.arp_opcode = flip16;
              if (it.arp_opcode == arpc_pkg::OPC_REQUEST ||
                  it.arp_opcode == arpc_pkg::OPC_REPLY)
                it.arp_opcode = ~it.arp_opcode;
            end
          endcase
        end
      end
      send_q.push_back(it);
    end
  endtask

  task automatic drain();
    while (send_q.size() > 0 || in_busy || expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin : sequencer
    arpc_pkg::arpc_in_t bad;
    logic [63:0]        wide;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_regs(32'h0A00_0005, 48'h0200_0000_0005, 32'h0A00_0001, 32'hFFFF_FF00);
    send_q.push_back(lookup_item(32'h0A00_0009));
    send_q.push_back(lookup_item(32'h0000_0000));
    send_q.push_back(lookup_item(32'hFFFF_FFFF));
    send_q.push_back(arp_packet(arpc_pkg::OPC_REPLY, 48'h0, 32'h0A00_0009, 32'h0));
    send_q.push_back(lookup_item(32'h0A00_0009));
    send_q.push_back(arp_packet(arpc_pkg::OPC_REQUEST, arpc_pkg::BCAST_MAC,
                                32'h0A00_0007, my_ip));
    send_q.push_back(arp_packet(arpc_pkg::OPC_REQUEST, 48'h02AA_BBCC_DDEE, 32'h0A00_0008,
                                32'h0A00_0063));
    // same address learned twice, the older entry must still win
    send_q.push_back(arp_packet(arpc_pkg::OPC_REPLY, 48'h0123_4567_89AB, 32'h0A00_0009,
                                32'h0));
    send_q.push_back(lookup_item(32'h0A00_0009));
    send_q.push_back(arp_packet(arpc_pkg::OPC_REPLY, 48'h0000_5E00_0101, 32'h0A00_0001,
                                my_ip));
    send_q.push_back(lookup_item(32'hC0A8_0101));
    send_q.push_back(lookup_item(32'h0A00_0001));
    send_q.push_back(lookup_item(32'h0A00_0007));
    bad = arp_packet(arpc_pkg::OPC_REQUEST, 48'h0600_0000_0042, 32'h0A00_0042, my_ip);
    bad.hw_type = 16'hFFFF;
    send_q.push_back(bad);
    bad = arp_packet(arpc_pkg::OPC_REPLY, 48'h0600_0000_0042, 32'h0A00_0042, my_ip);
    bad.proto_type = 16'h86DD;
    send_q.push_back(bad);
    bad.proto_type = arpc_pkg::PTYPE_IPV4;
    bad.hw_addr_len = 8'h00;
    send_q.push_back(bad);
    bad.hw_addr_len = arpc_pkg::HLEN_ETHERNET;
    bad.proto_addr_len = 8'hFF;
    send_q.push_back(bad);
    bad.proto_addr_len = arpc_pkg::PLEN_IPV4;
    bad.arp_opcode = 16'h0000;
    send_q.push_back(bad);
    bad.arp_opcode = 16'h0003;
    send_q.push_back(bad);
    bad.arp_opcode = 16'hFFFF;
    send_q.push_back(bad);
    // malformed packets must not have been learned
    send_q.push_back(lookup_item(32'h0A00_0042));
    send_q.push_back(arp_packet(arpc_pkg::OPC_REQUEST, 48'h0, 32'h0, my_ip));
    send_q.push_back(lookup_item(32'h0A00_0000));
    queue_random(240);
    drain();

    program_regs('0, '0, '0, '0);
    queue_random(270);
    drain();

    program_regs('1, '1, '1, '1);
    queue_random(270);
    hold_req = 1'b1;
    drain();

    wide = {$urandom, $urandom};
    program_regs(wide[31:0], wide[63:16], $urandom, 32'hFFFF_0000);
    queue_random(270);
    drain();

    quiet = 1'b1;
    wide = {$urandom, $urandom};
    program_regs(wide[63:32], wide[47:0], $urandom, 32'hFFFF_FFF0);
    queue_random(300);
    drain();

    if (err_count == 0) begin
      $display("arp_cache_responder_unit regression: pass");
    end else begin
      $display("arp_cache_responder_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("arp_cache_responder_unit regression: fail");
    $finish;
  end

endmodule
